/* rtl/npc_pkg.sv */
package npc_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int LEN_W       = $clog2(MAX_ENTRIES + 1);

    localparam int CFG_W   = 9;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 24;
    localparam int CH_W    = 8;
    localparam int SQ_W    = 2 * CH_W;
    localparam int DIST_W  = 18;

    localparam logic [CFG_W-1:0]  LEN_RESET  = 9'd256;
    localparam logic [DIST_W-1:0] DIST_START = 18'd195075;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [COLOR_W-1:0] RED_MASK   = 24'hFF0000;
    localparam logic [COLOR_W-1:0] GREEN_MASK = 24'h00FF00;
    localparam logic [COLOR_W-1:0] BLUE_MASK  = 24'h0000FF;

    typedef struct packed {
        logic               opcode;
        logic [IDX_W-1:0]   entry_index;
        logic [COLOR_W-1:0] color;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]  match_index;
        logic              found;
        logic [DIST_W-1:0] best_distance;
    } out_word_t;

    // squared channel differences of one palette entry
    typedef struct packed {
        logic              v;
        logic [ADDR_W-1:0] idx;
        logic [SQ_W-1:0]   sq_r;
        logic [SQ_W-1:0]   sq_g;
        logic [SQ_W-1:0]   sq_b;
    } dist_t;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [CH_W-1:0] red_of(input logic [COLOR_W-1:0] c);
        red_of = CH_W'((c & RED_MASK) >> 16);
    endfunction

    function automatic logic [CH_W-1:0] green_of(input logic [COLOR_W-1:0] c);
        green_of = CH_W'((c & GREEN_MASK) >> 8);
    endfunction

    function automatic logic [CH_W-1:0] blue_of(input logic [COLOR_W-1:0] c);
        blue_of = CH_W'(c & BLUE_MASK);
    endfunction

endpackage

/* rtl/npc_ifs.sv */
interface npc_in_if (input logic clk);
    npc_pkg::in_word_t data;
    logic              valid;
    logic              ready;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface npc_out_if (input logic clk);
    npc_pkg::out_word_t data;
    logic               valid;
    logic               ready;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/npc_palette_ram.sv */
module npc_palette_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [npc_pkg::ADDR_W-1:0]  waddr,
    input  logic [npc_pkg::COLOR_W-1:0] wdata,
    input  logic                        re,
    input  logic [npc_pkg::ADDR_W-1:0]  raddr,
    output logic [npc_pkg::COLOR_W-1:0] rdata
);
    import npc_pkg::*;

    logic [COLOR_W-1:0] mem [MAX_ENTRIES];
    logic [COLOR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/npc_dist.sv */
module npc_dist (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_v,
    input  logic [npc_pkg::ADDR_W-1:0]  in_idx,
    input  logic [npc_pkg::COLOR_W-1:0] entry,
    input  logic [npc_pkg::COLOR_W-1:0] target,
    output npc_pkg::dist_t              terms
);
    import npc_pkg::*;

    logic [CH_W-1:0]   d_r, d_g, d_b;
    logic              v_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [SQ_W-1:0]   sq_r_reg;
    logic [SQ_W-1:0]   sq_g_reg;
    logic [SQ_W-1:0]   sq_b_reg;

    assign d_r = abs_diff(red_of(entry), red_of(target));
    assign d_g = abs_diff(green_of(entry), green_of(target));
    assign d_b = abs_diff(blue_of(entry), blue_of(target));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= in_v;
        end
    end

    // 8x8 squares, one per channel
    always_ff @(posedge clk)
    begin
        idx_reg  <= in_idx;
        sq_r_reg <= SQ_W'(d_r * d_r);
        sq_g_reg <= SQ_W'(d_g * d_g);
        sq_b_reg <= SQ_W'(d_b * d_b);
    end

    assign terms = {v_reg, idx_reg, sq_r_reg, sq_g_reg, sq_b_reg};

endmodule

/* rtl/nearest_palette_color_match.sv */
// Channel   Dir  Payload                                  Handshake
// cmd       in   opcode, entry_index, color               valid/ready
// res       out  match_index, found, best_distance        valid/ready
// cfg       in   palette_length (9 bits)                  cfg_we, no ready
//
// A search word scans n = min(palette_length, palette depth) entries; the
// single read port of the palette RAM sets the one-entry-per-cycle scan.
// Length zero goes straight to the result stage and returns "nothing found".
// Reset: control clears, palette_length goes to 256; RAM contents are
// undefined until written (no clearing pass).
// cmd.ready is high only while idle; a finished result sits in the output
// register, so the next word is taken while res stalls.
module nearest_palette_color_match (
    input  logic                      clk,
    input  logic                      rst_n,
    npc_in_if.sink                    cmd,
    npc_out_if.source                 res,
    input  logic                      cfg_we,
    input  logic [npc_pkg::CFG_W-1:0] cfg_wdata
);
    import npc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;   // issuing RAM reads, top index down
    localparam logic [1:0] ST_DRAIN = 2'd2;   // waiting for the pipe to empty
    localparam logic [1:0] ST_DONE  = 2'd3;   // result ready for output register

    logic [1:0]         state_reg, state_next;
    logic [CFG_W-1:0]   len_reg;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [COLOR_W-1:0] target_reg;
    logic               s1_v_reg;
    logic [ADDR_W-1:0]  s1_idx_reg;

    logic [DIST_W-1:0]  best_reg, best_next;
    logic [ADDR_W-1:0]  best_idx_reg, best_idx_next;
    logic               found_reg, found_next;

    logic               out_valid_reg;
    out_word_t          out_word_reg;

    logic               accept;
    logic               is_search;
    logic [LEN_W-1:0]   n_eff;
    logic               ram_we;
    logic               ram_re;
    logic [COLOR_W-1:0] ram_rdata;
    logic               out_free;
    logic               load_out;
    logic [DIST_W-1:0]  sum;
    dist_t              dist_q;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign is_search = (cmd.data.opcode == OP_SEARCH);

    // clamp length to the palette depth
    assign n_eff = (32'(len_reg) > MAX_ENTRIES) ? LEN_W'(MAX_ENTRIES) : LEN_W'(len_reg);

    // writes land only while idle, reads only while scanning: no overlap on
    // the RAM, so no forwarding is needed
    assign ram_we = accept && (cmd.data.opcode == OP_WRITE)
                    && (32'(cmd.data.entry_index) < MAX_ENTRIES);
    assign ram_re = (state_reg == ST_RUN);

    npc_palette_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(cmd.data.entry_index)),
        .wdata (cmd.data.color),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    npc_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_v   (s1_v_reg),
        .in_idx (s1_idx_reg),
        .entry  (ram_rdata),
        .target (target_reg),
        .terms  (dist_q)
    );

    assign sum = DIST_W'(dist_q.sq_r) + DIST_W'(dist_q.sq_g) + DIST_W'(dist_q.sq_b);

    assign out_free = !out_valid_reg || res.ready;
    assign load_out = (state_reg == ST_DONE) && out_free;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_search)
                begin
                    if (n_eff == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        addr_next  = ADDR_W'(n_eff - LEN_W'(1));
                    end
                end
            end
            ST_RUN:
            begin
                if (addr_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg - ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!s1_v_reg && !dist_q.v)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // running best; strict less keeps the higher index on ties
    always_comb
    begin
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        if (accept && is_search)
        begin
            best_next     = DIST_START;
            best_idx_next = '0;
            found_next    = 1'b0;
        end
        else if (dist_q.v && (sum < best_reg))
        begin
            best_next     = sum;
            best_idx_next = dist_q.idx;
            found_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_RESET;
            s1_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            best_reg      <= DIST_START;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_v_reg     <= ram_re;
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
            found_reg    <= found_next;
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        s1_idx_reg <= addr_reg;
        if (accept)
        begin
            target_reg <= cmd.data.color;
        end
        if (load_out)
        begin
            out_word_reg.match_index   <= IDX_W'(best_idx_reg);
            out_word_reg.found         <= found_reg;
            out_word_reg.best_distance <= best_reg;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_word_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // distance pipe only carries entries of an active scan
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dist_q.v |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("distance stage valid outside a scan");

    // result is formed only after the last entry was compared
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!s1_v_reg && !dist_q.v))
        else $error("result stage entered with entries in flight");

    // best distance tracks the found flag
    a_best_found: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg ? (best_reg < DIST_START) : (best_reg == DIST_START && best_idx_reg == '0))
        else $error("best distance inconsistent with found flag");

    // a delivered "not found" result carries the start distance and index zero
    a_out_notfound: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.data.found) |->
            (res.data.best_distance == DIST_START && res.data.match_index == '0))
        else $error("not-found result with bad payload");

endmodule
